// ===== sv/lric_pkg.sv =====
// Shared types and constants for the local radius index code block.
// No dependencies; lric_ray, the top level and the testbench use this package.
`default_nettype none

package lric_pkg;

  localparam int PIX_W  = 8;
  localparam int CODE_W = 4;
  localparam int COL_W  = 10;
  localparam int LW_W   = 11;
  localparam int THR_W  = 12;

  localparam int LW_RESET  = 640;
  localparam int THR_RESET = 32;

  // Ray order: E, NE, N, NW, W, SW, S, SE (row offset, column offset)
  localparam int NUM_RAYS = 8;
  localparam int RAY_DR [NUM_RAYS] = '{0, -1, -1, -1, 0, 1, 1, 1};
  localparam int RAY_DC [NUM_RAYS] = '{1, 1, 0, -1, -1, -1, 0, 1};

  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_THRESHOLD_Q4 = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e           index;
    logic [THR_W-1:0]   value;
  } cfg_wr_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] code_east;
    logic signed [CODE_W-1:0] code_northeast;
    logic signed [CODE_W-1:0] code_north;
    logic signed [CODE_W-1:0] code_northwest;
    logic signed [CODE_W-1:0] code_west;
    logic signed [CODE_W-1:0] code_southwest;
    logic signed [CODE_W-1:0] code_south;
    logic signed [CODE_W-1:0] code_southeast;
    logic [COL_W-1:0]         center_column;
  } lri_res_t;

endpackage

`default_nettype wire

// ===== sv/lric_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// Payload type is set per instance; used with types from lric_pkg.
`default_nettype none

interface lric_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/lric_line_store.sv =====
// Line store: one synchronous RAM word per column holding every buffered row.
// Registered read data, write-to-read forwarding for the same column.
`default_nettype none

module lric_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 64,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

// ===== sv/lric_ray.sv =====
// Run code for one ray: counts the leading neighbours above or below the
// centre by more than the threshold. Depends on lric_pkg.
`default_nettype none

module lric_ray #(
  parameter int RADIUS = 4
) (
  input  wire logic [lric_pkg::PIX_W-1:0]  center_i,
  input  wire logic [lric_pkg::PIX_W-1:0]  nb_i [RADIUS],
  input  wire logic [lric_pkg::THR_W-1:0]  thr_i,
  output logic signed [lric_pkg::CODE_W-1:0] code_o
);

  localparam int SUM_W = lric_pkg::PIX_W + 6;
  localparam int CNT_W = $clog2(RADIUS + 1);

  logic [SUM_W-1:0] c16;
  logic [SUM_W-1:0] c16_hi;
  logic [RADIUS-1:0] above;
  logic [RADIUS-1:0] below;
  logic [CNT_W-1:0] n_above;
  logic [CNT_W-1:0] n_below;
  logic             run_a;
  logic             run_b;

  assign c16    = {2'b00, center_i, 4'b0000};
  assign c16_hi = c16 + SUM_W'(thr_i);

  always_comb begin
    n_above = '0;
    n_below = '0;
    run_a   = 1'b1;
    run_b   = 1'b1;
    for (int i = 0; i < RADIUS; i++) begin
      above[i] = {2'b00, nb_i[i], 4'b0000} > c16_hi;
      below[i] = ({2'b00, nb_i[i], 4'b0000} + SUM_W'(thr_i)) < c16;
      run_a = run_a & above[i];
      run_b = run_b & below[i];
      if (run_a) begin
        n_above = n_above + CNT_W'(1);
      end
      if (run_b) begin
        n_below = n_below + CNT_W'(1);
      end
    end
    if (above[0]) begin
      code_o = signed'(lric_pkg::CODE_W'(n_above));
    end else begin
      code_o = -signed'(lric_pkg::CODE_W'(n_below));
    end
  end

endmodule

`default_nettype wire

// ===== sv/local_radius_index_codes.sv =====
// Top level of the local radius index code generator.
// Depends on lric_pkg, lric_chan_if, lric_line_store and lric_ray.
//
// Usage:
//   pix_i  : raster-order pixels with a frame-start flag, one per transfer.
//   res_o  : eight signed ray codes and the centre column, one transfer per
//            pixel whose (2*RADIUS+1)-square window lies inside the image.
//   cfg_i  : register writes (line width, threshold in 1/16 units); always
//            ready, to be used only while the block is idle.
// Throughput: one pixel per cycle while res_o accepts results. The line store is a single
// RAM word per column, read and rewritten once per pixel.
// Each pixel transfer passes the RAM read, the window shift and code evaluation
// into the output queue, from which its result is offered.
// Stalls: a four-entry output queue absorbs back-pressure; pix_i.ready drops
// when queued plus in-flight items fill it.
// Reset: counters clear, registers take line width 640 and threshold 32;
// line store and window contents are undefined until a frame is streamed.
`default_nettype none

module local_radius_index_codes #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lric_chan_if.sink   cfg_i,
  lric_chan_if.sink   pix_i,
  lric_chan_if.source res_o
);

  localparam int PW     = lric_pkg::PIX_W;
  localparam int LINES  = 2 * RADIUS;
  localparam int WSIZE  = 2 * RADIUS + 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EW     = (CW + 1 > lric_pkg::LW_W) ? CW + 1 : lric_pkg::LW_W;
  localparam int RW     = $clog2(LINES + 1);
  localparam int DW     = LINES * PW;
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  // Configuration
  logic [lric_pkg::LW_W-1:0]  line_width_q;
  logic [lric_pkg::THR_W-1:0] thr_q;
  lric_pkg::cfg_wr_t          cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= lric_pkg::LW_W'(lric_pkg::LW_RESET);
      thr_q        <= lric_pkg::THR_W'(lric_pkg::THR_RESET);
    end else if (cfg_i.valid) begin
      case (cfg_wr.index)
        lric_pkg::REG_LINE_WIDTH:   line_width_q <= cfg_wr.value[lric_pkg::LW_W-1:0];
        lric_pkg::REG_THRESHOLD_Q4: thr_q        <= cfg_wr.value;
        default: ;
      endcase
    end
  end

  // Stage 0: position counters at the input transfer
  logic [CW-1:0] column_count_q, column_count_d;
  logic [RW-1:0] rows_seen_q, rows_seen_d;
  logic [CW-1:0] col;
  logic [RW-1:0] rows;
  logic [EW-1:0] lw_ext, eff_w, col_next;
  logic          emit, last, pix_acc;
  lric_pkg::pix_in_t pix;

  logic          s1_v_q, s1_emit_q;
  logic [CW-1:0] s1_col_q;
  logic [PW-1:0] s1_px_q;
  logic          s2_v_q, s2_emit_q;
  logic [CW-1:0] s2_col_q;
  logic [QPW:0]  occ_q;

  assign pix     = pix_i.data;
  assign pix_i.ready = (32'(occ_q) + 32'(s1_v_q) + 32'(s2_v_q)) < QDEPTH;
  assign pix_acc = pix_i.valid && pix_i.ready;

  always_comb begin
    col      = pix.frame_start ? '0 : column_count_q;
    rows     = pix.frame_start ? '0 : rows_seen_q;
    emit     = (rows >= RW'(LINES)) && (col >= CW'(LINES));
    lw_ext   = EW'(line_width_q);
    if (lw_ext < EW'(WSIZE)) begin
      eff_w = EW'(WSIZE);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    col_next = EW'(col) + EW'(1);
    last     = col_next >= eff_w;
    if (last) begin
      column_count_d = '0;
      rows_seen_d    = (rows < RW'(LINES)) ? rows + RW'(1) : rows;
    end else begin
      column_count_d = col_next[CW-1:0];
      rows_seen_d    = rows;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      rows_seen_q    <= '0;
      s1_v_q         <= 1'b0;
      s1_emit_q      <= 1'b0;
      s2_v_q         <= 1'b0;
      s2_emit_q      <= 1'b0;
    end else begin
      if (pix_acc) begin
        column_count_q <= column_count_d;
        rows_seen_q    <= rows_seen_d;
      end
      s1_v_q    <= pix_acc;
      s1_emit_q <= pix_acc && emit;
      s2_v_q    <= s1_v_q;
      s2_emit_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_col_q <= col;
      s1_px_q  <= pix.pixel;
    end
    if (s1_v_q) begin
      s2_col_q <= s1_col_q;
    end
  end

  // Stage 1: line store read-modify-write and window shift
  logic [DW-1:0] ls_rd;
  logic [DW-1:0] ls_wr;

  assign ls_wr = {ls_rd[DW-PW-1:0], s1_px_q};

  lric_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (DW),
    .ADDR_W (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (pix_acc),
    .rd_addr_i (col),
    .wr_en_i   (s1_v_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (ls_wr),
    .rd_data_o (ls_rd)
  );

  logic [PW-1:0] win_q [WSIZE][WSIZE];

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int r = 0; r < WSIZE; r++) begin
        for (int c = 0; c < WSIZE - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      for (int r = 0; r < LINES; r++) begin
        win_q[r][WSIZE-1] <= ls_rd[PW*(LINES-1-r) +: PW];
      end
      win_q[LINES][WSIZE-1] <= s1_px_q;
    end
  end

  // Stage 2: ray codes from the updated window
  logic signed [lric_pkg::CODE_W-1:0] code [lric_pkg::NUM_RAYS];

  for (genvar d = 0; d < lric_pkg::NUM_RAYS; d++) begin : g_ray
    logic [PW-1:0] nb [RADIUS];
    for (genvar i = 1; i <= RADIUS; i++) begin : g_nb
      assign nb[i-1] = win_q[RADIUS + i * lric_pkg::RAY_DR[d]]
                            [RADIUS + i * lric_pkg::RAY_DC[d]];
    end
    lric_ray #(
      .RADIUS (RADIUS)
    ) u_ray (
      .center_i (win_q[RADIUS][RADIUS]),
      .nb_i     (nb),
      .thr_i    (thr_q),
      .code_o   (code[d])
    );
  end

  logic [EW-1:0]      ctr_full;
  lric_pkg::lri_res_t res_d;

  assign ctr_full = EW'(s2_col_q) - EW'(RADIUS);

  always_comb begin
    res_d.code_east      = code[0];
    res_d.code_northeast = code[1];
    res_d.code_north     = code[2];
    res_d.code_northwest = code[3];
    res_d.code_west      = code[4];
    res_d.code_southwest = code[5];
    res_d.code_south     = code[6];
    res_d.code_southeast = code[7];
    res_d.center_column  = ctr_full[lric_pkg::COL_W-1:0];
  end

  // Output queue
  lric_pkg::lri_res_t q_mem [QDEPTH];
  logic [QPW-1:0]     wr_ptr_q, rd_ptr_q;
  logic               push, pop;

  assign push        = s2_v_q && s2_emit_q;
  assign pop         = res_o.valid && res_o.ready;
  assign res_o.valid = occ_q != '0;
  assign res_o.data  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPW'(1);
      end
      if (push && !pop) begin
        occ_q <= occ_q + (QPW+1)'(1);
      end else if (pop && !push) begin
        occ_q <= occ_q - (QPW+1)'(1);
      end
    end
  end

  // Checks
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (occ_q < (QPW+1)'(QDEPTH)) || pop)
    else $error("output queue overflow");

  a_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(occ_q) + 32'(s1_v_q) + 32'(s2_v_q)) <= QDEPTH)
    else $error("in-flight items exceed queue space");

  a_rows_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q <= RW'(LINES))
    else $error("row counter beyond saturation");

  a_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> s1_v_q ##1 s2_v_q)
    else $error("pipeline lost an item");

endmodule

`default_nettype wire

// ===== dv/local_radius_index_codes_test.sv =====
// Testbench for local_radius_index_codes: streams raster images through the pixel channel,
// predicts the eight ray codes of every complete 9x9 window and checks each result transfer.
// Depends on lric_pkg, lric_chan_if and the block's RTL.
module local_radius_index_codes_test;
  import lric_pkg::*;

  localparam int MAX_W = 1024;
  localparam int RAD   = 4;
  localparam int SPAN  = 2 * RAD + 1;
  localparam int LINES = 2 * RAD;
  localparam int NRAYS = 8;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 12;

  localparam int STEP_R [NRAYS] = '{0, -1, -1, -1, 0, 1, 1, 1};
  localparam int STEP_C [NRAYS] = '{1, 1, 0, -1, -1, -1, 0, 1};

  typedef enum int {FILL_RANDOM, FILL_TWO_LEVEL, FILL_NEAR, FILL_EXTREME} fill_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lric_chan_if #(.T(cfg_wr_t))  cfg_if ();
  lric_chan_if #(.T(pix_in_t))  pix_if ();
  lric_chan_if #(.T(lri_res_t)) res_if ();

  local_radius_index_codes #(
    .MAX_WIDTH(MAX_W),
    .RADIUS   (RAD)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .pix_i (pix_if),
    .res_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [PIX_W-1:0] line_mem [LINES][MAX_W];
  logic [PIX_W-1:0] win [SPAN][SPAN];
  int unsigned      col_next;
  int unsigned      rows_done;
  logic [LW_W-1:0]  width_reg;
  logic [THR_W-1:0] thr_reg;
  lri_res_t         pending_codes [$];

  int unsigned err_count;
  int unsigned cycles;
  int          gap_max;
  int          burst_max;
  int          burst_left;
  stall_e      stall_mode;
  string       ray_name [NRAYS] = '{"east", "northeast", "north", "northwest",
                                    "west", "southwest", "south", "southeast"};

  function automatic logic signed [CODE_W-1:0] ray_run(int d);
    int centre16;
    int p16;
    int t;
    int run;
    int i;
    centre16 = 16 * int'(win[RAD][RAD]);
    t        = int'(thr_reg);
    run      = 0;
    for (i = 1; i <= RAD; i++) begin
      p16 = 16 * int'(win[RAD + i * STEP_R[d]][RAD + i * STEP_C[d]]);
      if (p16 > centre16 + t && run == i - 1) run = i;
      else if (p16 < centre16 - t && run == 1 - i) run = -i;
      else break;
    end
    return run[CODE_W-1:0];
  endfunction

  function automatic void predict_window_codes(logic [PIX_W-1:0] px, logic fs);
    int unsigned w;
    int unsigned col;
    bit          emit;
    lri_res_t    res;
    w = width_reg;
    if (w < SPAN) w = SPAN;
    if (w > MAX_W) w = MAX_W;
    if (fs) begin
      col_next  = 0;
      rows_done = 0;
    end
    col = col_next;
    for (int rr = 0; rr < SPAN; rr++)
      for (int cc = 0; cc < SPAN - 1; cc++)
        win[rr][cc] = win[rr][cc + 1];
    for (int rr = 0; rr < LINES; rr++)
      win[rr][SPAN-1] = line_mem[LINES-1-rr][col];
    win[SPAN-1][SPAN-1] = px;
    for (int k = LINES - 1; k > 0; k--)
      line_mem[k][col] = line_mem[k-1][col];
    line_mem[0][col] = px;
    emit = rows_done >= LINES && col >= LINES;
    if (col + 1 >= w) begin
      col_next = 0;
      if (rows_done < LINES) rows_done++;
    end else begin
      col_next = col + 1;
    end
    if (emit) begin
      res.code_east      = ray_run(0);
      res.code_northeast = ray_run(1);
      res.code_north     = ray_run(2);
      res.code_northwest = ray_run(3);
      res.code_west      = ray_run(4);
      res.code_southwest = ray_run(5);
      res.code_south     = ray_run(6);
      res.code_southeast = ray_run(7);
      res.center_column  = COL_W'(col - RAD);
      pending_codes.push_back(res);
    end
  endfunction

  function automatic logic signed [CODE_W-1:0] code_of(lri_res_t x, int d);
    return x[COL_W + (NRAYS - 1 - d) * CODE_W +: CODE_W];
  endfunction

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    err_count++;
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    lri_res_t got;
    lri_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_codes.size() == 0) begin
        report($sformatf("result transfer with nothing expected, column %0d",
                         got.center_column));
      end else begin
        want = pending_codes.pop_front();
        for (int d = 0; d < NRAYS; d++)
          if (code_of(got, d) !== code_of(want, d))
            report($sformatf("column %0d %s code: got %0d expected %0d", want.center_column,
                             ray_name[d], code_of(got, d), code_of(want, d)));
        if (got.center_column !== want.center_column)
          report($sformatf("center column: got %0d expected %0d",
                           got.center_column, want.center_column));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    case (stall_mode)
      STALL_NONE:     res_if.ready <= 1'b1;
      STALL_LIGHT:    res_if.ready <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: res_if.ready <= (cycles % 11) < 6;
      default:        res_if.ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic set_idling(int gmax, int bmax, stall_e s);
    gap_max    = gmax;
    burst_max  = bmax;
    burst_left = 0;
    stall_mode = s;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic fs);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, burst_max);
      if (gap > 0) begin
        @(negedge clk_i);
        pix_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    pix_if.valid <= 1'b1;
    pix_if.data  <= '{pixel: px, frame_start: fs};
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    predict_window_codes(px, fs);
  endtask

  function automatic logic [PIX_W-1:0] fill_pixel(fill_e mode);
    case (mode)
      FILL_TWO_LEVEL: return $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                                  : 8'($urandom_range(0, 15));
      FILL_NEAR:      return 8'(97 + $urandom_range(0, 6));
      FILL_EXTREME:   return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:        return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixels(int unsigned count, fill_e mode, bit new_frame);
    for (int unsigned n = 0; n < count; n++)
      send_pixel(fill_pixel(mode), new_frame && n == 0);
  endtask

  // Stop the stream, let every expected transfer arrive, then allow for in-flight pixels
  task automatic settle();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: THR_W'(value)};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == REG_LINE_WIDTH) width_reg = LW_W'(value);
    else thr_reg = THR_W'(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Threshold left at its reset value; neighbours sit on and either side of it
  task automatic test_default_threshold();
    set_idling(0, 1, STALL_NONE);
    write_reg(REG_LINE_WIDTH, 9);
    send_pixels(9 * 10, FILL_NEAR, 1'b1);
    settle();
  endtask

  // Same image continued, threshold changed between rows
  task automatic test_threshold_extremes();
    set_idling(2, 4, STALL_LIGHT);
    write_reg(REG_THRESHOLD_Q4, 0);
    send_pixels(9 * 2, FILL_NEAR, 1'b0);
    settle();
    write_reg(REG_THRESHOLD_Q4, 4095);
    send_pixels(9 * 2, FILL_EXTREME, 1'b0);
    settle();
    write_reg(REG_THRESHOLD_Q4, 40);
    send_pixels(9 * 2, FILL_NEAR, 1'b0);
    settle();
    write_reg(REG_THRESHOLD_Q4, 32);
  endtask

  // Widths below the window span clamp to it; the image carries on
  task automatic test_width_clamp_low();
    set_idling(1, 8, STALL_PERIODIC);
    write_reg(REG_LINE_WIDTH, 0);
    send_pixels(9 * 2, FILL_TWO_LEVEL, 1'b0);
    settle();
    write_reg(REG_LINE_WIDTH, 5);
    send_pixels(9 * 2 + 4, FILL_EXTREME, 1'b0);
    settle();
  endtask

  // New image begins part way through a row
  task automatic test_frame_restart();
    set_idling(0, 1, STALL_HEAVY);
    write_reg(REG_LINE_WIDTH, 12);
    send_pixels(12 + 5, FILL_RANDOM, 1'b1);
    send_pixels(12 * 9, FILL_TWO_LEVEL, 1'b1);
    settle();
  endtask

  // Width narrowed past the current column: that row ends on the next pixel
  task automatic test_width_shrink_mid_row();
    set_idling(3, 3, STALL_LIGHT);
    send_pixels(12 + 10, FILL_TWO_LEVEL, 1'b0);
    settle();
    write_reg(REG_LINE_WIDTH, 9);
    send_pixels(1 + 9 * 2, FILL_RANDOM, 1'b0);
    settle();
  endtask

  // Over-range width clamps to the widest row; a short first row gives no result
  task automatic test_widest_rows();
    set_idling(1, 16, STALL_LIGHT);
    write_reg(REG_THRESHOLD_Q4, 16);
    write_reg(REG_LINE_WIDTH, 2047);
    send_pixels(40, FILL_RANDOM, 1'b1);
    settle();
  endtask

  task automatic test_random_images();
    int unsigned sent;
    int unsigned w;
    int unsigned eff;
    int unsigned rows;
    int unsigned count;
    sent = 0;
    eff  = 9;
    while (sent < 120) begin
      if (sent == 0 || $urandom_range(0, 2) != 0) begin
        settle();
        case ($urandom_range(0, 3))
          0:       write_reg(REG_THRESHOLD_Q4, $urandom_range(0, 4095));
          1:       write_reg(REG_THRESHOLD_Q4, $urandom_range(0, 400));
          default: write_reg(REG_THRESHOLD_Q4, $urandom_range(0, 64));
        endcase
        w = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 14);
        write_reg(REG_LINE_WIDTH, w);
        eff = (w < SPAN) ? SPAN : w;
        set_idling($urandom_range(0, 1) ? 0 : $urandom_range(1, 3),
                   $urandom_range(1, 20), stall_e'($urandom_range(0, 3)));
      end
      rows  = $urandom_range(9, 10);
      count = eff * rows + $urandom_range(0, eff - 1);
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
      send_pixels(count, fill_e'($urandom_range(0, 3)), 1'b1);
      sent += count;
    end
    settle();
  endtask

  initial begin
    pix_if.valid    = 1'b0;
    pix_if.data     = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    res_if.ready    = 1'b0;
    err_count       = 0;
    cycles          = 0;
    col_next        = 0;
    rows_done       = 0;
    width_reg       = LW_W'(LW_RESET);
    thr_reg         = THR_W'(THR_RESET);
    set_idling(0, 1, STALL_NONE);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_threshold();
    test_threshold_extremes();
    test_width_clamp_low();
    test_frame_restart();
    test_width_shrink_mid_row();
    test_widest_rows();
    test_random_images();

    settle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
